[sv/msb_first_bit_packer_with_guid_modes_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the MSB-first bit packer
// Concurrent assertion shorthands with a clock, a reset and a message.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_WITH_GUID_MODES_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_WITH_GUID_MODES_MACROS_SVH

// same-cycle implication
`define MSBBP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSBBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/msbbp_pkg.sv]
// ----------------------------------------------------------------------------
// msbbp_pkg
// Function codes and fixed sizes of the MSB-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package msbbp_pkg;

  localparam int BYTE_W      = 8;
  localparam int N_ID_BYTES  = 8;
  localparam int N_ORDER     = 8;
  localparam int MAX_RESULTS = 10;

  typedef enum logic [2:0] {
    FUNC_BITS    = 3'd0,
    FUNC_BYTE    = 3'd1,
    FUNC_FLUSH   = 3'd2,
    FUNC_PACKED  = 3'd3,
    FUNC_IDMASK  = 3'd4,
    FUNC_IDBYTES = 3'd5
  } func_t;

endpackage

`default_nettype wire

[sv/msb_first_bit_packer_with_guid_modes.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_packer_with_guid_modes
// Packs bits MSB first into a pending byte and serializes 64-bit ids.
// Path: an input transfer is registered in the input stage, then loaded into the
//   result buffer, from which its first output byte is sent. Throughput, while
//   m_tready is high: one item per cycle while items give at most one byte; else
//   one byte per cycle, as the one-byte output port drains the ten-entry buffer.
// Reset: synchronous; empties the pending byte, the input stage and the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "msb_first_bit_packer_with_guid_modes_macros.svh"

module msb_first_bit_packer_with_guid_modes (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [103:0] s_tdata,  // value[63:0], count[70:64], order[102:71], pad
  input  wire logic [2:0]   s_tuser,  // func[2:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,  // byte_out[7:0]
  output logic              m_tlast
);

  localparam int NB = msbbp_pkg::N_ID_BYTES;
  localparam int NR = msbbp_pkg::MAX_RESULTS;

  // input stage
  logic        s1_valid;
  logic [2:0]  s1_func;
  logic [63:0] s1_value;
  logic [6:0]  s1_count;
  logic [31:0] s1_order;

  // packer state
  logic [7:0]  pending_byte;
  logic [3:0]  free_bit_pos;
  logic [7:0]  pending_byte_next;
  logic [3:0]  free_bit_pos_next;

  // result buffer
  logic [7:0]  out_buf [NR];
  logic [3:0]  out_cnt;
  logic [3:0]  out_idx;
  logic        busy;

  logic [7:0]  res [NR];
  logic [3:0]  res_n;

  logic        load;
  logic        drain;
  logic        drain_last;

  // shared decode
  logic [2:0]  fill;
  logic [3:0]  entries;
  logic [7:0]  idb [NB];
  logic [NB-1:0] nz;

  // bit path
  logic [7:0]  bits_v;
  logic [3:0]  bits_n;
  logic [6:0]  bc;
  logic [63:0] bv;
  logic [63:0] aligned;
  logic [71:0] stream;
  logic [6:0]  total;
  logic [7:0]  sbyte [NB+1];

  // byte path
  logic        flush_en;
  logic [7:0]  cand [NB+1];
  logic [NB:0] cv;
  logic [7:0]  list [NR];
  logic [3:0]  list_n;

  logic [7:0]  pend_low;

  assign fill    = 3'(4'd8 - free_bit_pos);
  assign entries = (s1_count > 7'd8) ? 4'd8 : s1_count[3:0];

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      idb[i] = s1_value[8*i +: 8];
      nz[i]  = (s1_value[8*i +: 8] != 8'd0);
    end
  end

  // mask bits in order, compacted
  always_comb begin
    logic [3:0] idx;
    bits_v = 8'd0;
    bits_n = 4'd0;
    for (int i = 0; i < msbbp_pkg::N_ORDER; i++) begin
      idx = s1_order[4*i +: 4];
      if ((4'(i) < entries) && !idx[3]) begin
        bits_v = {bits_v[6:0], nz[idx[2:0]]};
        bits_n = bits_n + 4'd1;
      end
    end
  end

  always_comb begin
    bc = 7'd0;
    bv = s1_value;
    case (s1_func)
      msbbp_pkg::FUNC_BITS: begin
        if (s1_count >= 7'd1 && s1_count <= 7'd64) begin
          bc = s1_count;
        end
      end
      msbbp_pkg::FUNC_IDMASK: begin
        bc = {3'd0, bits_n};
        bv = {56'd0, bits_v};
      end
      default: begin
        bc = 7'd0;
      end
    endcase
  end

  assign aligned = bv << (7'd64 - bc);
  assign stream  = {pending_byte, 64'd0} | ({aligned, 8'd0} >> fill);
  assign total   = {4'd0, fill} + bc;

  always_comb begin
    for (int j = 0; j <= NB; j++) begin
      sbyte[j] = stream[71 - 8*j -: 8];
    end
  end

  // byte-level candidates
  always_comb begin
    logic [3:0] idx;
    idx = 4'd0;
    for (int j = 0; j <= NB; j++) begin
      cand[j] = 8'd0;
    end
    cv       = '0;
    flush_en = 1'b0;
    case (s1_func)
      msbbp_pkg::FUNC_BYTE: begin
        flush_en = (fill != 3'd0);
        cand[0]  = s1_value[7:0];
        cv[0]    = 1'b1;
      end
      msbbp_pkg::FUNC_FLUSH: begin
        flush_en = (fill != 3'd0);
      end
      msbbp_pkg::FUNC_PACKED: begin
        flush_en = (fill != 3'd0);
        cand[0]  = nz;
        cv[0]    = 1'b1;
        for (int i = 0; i < NB; i++) begin
          cand[i+1] = idb[i];
          cv[i+1]   = nz[i];
        end
      end
      msbbp_pkg::FUNC_IDBYTES: begin
        for (int i = 0; i < msbbp_pkg::N_ORDER; i++) begin
          idx     = s1_order[4*i +: 4];
          cand[i] = idb[idx[2:0]] ^ 8'h01;
          cv[i]   = (4'(i) < entries) && !idx[3] && nz[idx[2:0]];
        end
        // flush only ahead of a byte that is actually sent
        flush_en = (fill != 3'd0) && (cv != '0);
      end
      default: begin
        flush_en = 1'b0;
      end
    endcase
  end

  // compact flush byte and candidates
  always_comb begin
    for (int j = 0; j < NR; j++) begin
      list[j] = 8'd0;
    end
    list_n = 4'd0;
    if (flush_en) begin
      list[0] = pending_byte;
      list_n  = 4'd1;
    end
    for (int j = 0; j <= NB; j++) begin
      if (cv[j]) begin
        list[list_n] = cand[j];
        list_n       = list_n + 4'd1;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      res[j] = 8'd0;
    end
    res_n             = 4'd0;
    pending_byte_next = pending_byte;
    free_bit_pos_next = free_bit_pos;
    case (s1_func)
      msbbp_pkg::FUNC_BITS, msbbp_pkg::FUNC_IDMASK: begin
        for (int j = 0; j < NB; j++) begin
          res[j] = sbyte[j];
        end
        res_n             = total[6:3];
        pending_byte_next = sbyte[total[6:3]];
        free_bit_pos_next = 4'd8 - {1'b0, total[2:0]};
      end
      msbbp_pkg::FUNC_BYTE, msbbp_pkg::FUNC_FLUSH,
      msbbp_pkg::FUNC_PACKED, msbbp_pkg::FUNC_IDBYTES: begin
        res   = list;
        res_n = list_n;
        if (flush_en) begin
          pending_byte_next = 8'd0;
          free_bit_pos_next = 4'd8;
        end
      end
      default: begin
        res_n = 4'd0;
      end
    endcase
  end

  assign m_tvalid   = busy;
  assign m_tdata    = out_buf[out_idx];
  assign m_tlast    = (out_idx == out_cnt - 4'd1);
  assign drain      = busy && m_tready;
  assign drain_last = drain && m_tlast;
  assign load       = s1_valid && (!busy || drain_last);
  assign s_tready   = !s1_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_func  <= s_tuser;
      s1_value <= s_tdata[63:0];
      s1_count <= s_tdata[70:64];
      s1_order <= s_tdata[102:71];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte <= 8'd0;
      free_bit_pos <= 4'd8;
    end else if (load) begin
      pending_byte <= pending_byte_next;
      free_bit_pos <= free_bit_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      out_idx <= 4'd0;
    end else if (load) begin
      busy    <= (res_n != 4'd0);
      out_idx <= 4'd0;
    end else if (drain_last) begin
      busy    <= 1'b0;
    end else if (drain) begin
      out_idx <= out_idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_buf <= res;
      out_cnt <= res_n;
    end
  end

  assign pend_low = 8'((9'd1 << free_bit_pos) - 9'd1);

  `MSBBP_ASSERT_SAME(a_free_range, clk, rst, 1'b1,
                     (free_bit_pos >= 4'd1) && (free_bit_pos <= 4'd8),
                     "free bit position out of range")
  `MSBBP_ASSERT_SAME(a_pend_clean, clk, rst, 1'b1, (pending_byte & pend_low) == 8'd0,
                     "unwritten pending bits not zero")
  `MSBBP_ASSERT_SAME(a_idx_bound, clk, rst, busy,
                     (out_idx < out_cnt) && (out_cnt <= 4'd10),
                     "result index past count")
  `MSBBP_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !load, s1_valid,
                     "input stage lost an item")
  `MSBBP_ASSERT_NEXT(a_flush_empty, clk, rst,
                     load && (s1_func == msbbp_pkg::FUNC_FLUSH), free_bit_pos == 4'd8,
                     "flush left pending bits")

endmodule

`default_nettype wire
